// ===== sv/gregorian_date_add_days_defines.svh =====
// assertion macros shared by the date-add rtl
// no dependencies; included by files that carry concurrent checks
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

// same-cycle implication check
`define GDAD_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check
`define GDAD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gdad_pkg.sv =====
// shared types, constants and calendar functions for the date-add block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 15;
  localparam int REM_W   = 16;   // day + add + days before month, max 33133
  localparam int CUM_W   = 9;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // multiplicative inverse of 25 modulo 2^14, divisibility test by 25
  localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [DAY_W-1:0] FEB_LEN      = 5'd28;

  // month lengths, index 0 is january; index by month - 1
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // days before the first of a month in a common year, indexed by month
  localparam logic [CUM_W-1:0] CUM_DAYS [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
  };

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [REM_W-1:0]   rem;
    logic               leap;
    logic               bad;
  } item_t;

  // leap when 4 | y and not 25 | y, or when 16 | y and 25 | y
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
    div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m == FEB) begin
      len = leap ? FEB_LEAP_LEN : FEB_LEN;
    end else if ((m >= JAN) && (m <= DEC)) begin
      len = MONTH_LEN[m - JAN];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gdad_front.sv =====
// front part: takes a request, checks the start date and forms the day count
// from the first of january; uses gdad_pkg
`timescale 1ns / 1ps
`default_nettype none

module gdad_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [gdad_pkg::IN_TDATA_W-1:0]    s_tdata,
  output      logic                               push_valid,
  input  wire logic                               push_ready,
  output      gdad_pkg::item_t                    push_item
);

  logic                             fr_valid;
  logic [gdad_pkg::YEAR_W-1:0]      fr_year;
  logic [gdad_pkg::MONTH_W-1:0]     fr_month;
  logic [gdad_pkg::DAY_W-1:0]       fr_day;
  logic [gdad_pkg::ADD_W-1:0]       fr_add;

  logic                             leap;
  logic [gdad_pkg::DAY_W-1:0]       len;
  logic                             feb_extra;

  assign s_tready   = !fr_valid || push_ready;
  assign push_valid = fr_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_tready) begin
      fr_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fr_year  <= s_tdata[13:0];
      fr_month <= s_tdata[17:14];
      fr_day   <= s_tdata[22:18];
      fr_add   <= s_tdata[37:23];
    end
  end

  always_comb begin
    leap      = gdad_pkg::is_leap(fr_year);
    len       = gdad_pkg::month_len(fr_month, leap);
    feb_extra = leap && (fr_month > gdad_pkg::FEB);

    push_item.year  = fr_year;
    push_item.month = fr_month;
    push_item.day   = fr_day;
    push_item.leap  = leap;
    push_item.bad   = (len == '0) || (fr_day == '0) || (fr_day > len);
    push_item.rem   = gdad_pkg::REM_W'(fr_day) + gdad_pkg::REM_W'(fr_add)
                    + gdad_pkg::REM_W'(gdad_pkg::CUM_DAYS[fr_month])
                    + gdad_pkg::REM_W'(feb_extra);
  end

endmodule

`default_nettype wire

// ===== sv/gdad_queue.sv =====
// short queue between front and back parts
// uses gdad_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_add_days_defines.svh"

module gdad_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire gdad_pkg::item_t  push_item,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      gdad_pkg::item_t  pop_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  gdad_pkg::item_t  entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `GDAD_ASSERT_NEXT(a_queue_fill, clk, rst, push && !pop, count == $past(count) + CW'(1), "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== sv/gdad_back.sv =====
// back part: walks month by month from january and holds the result
// uses gdad_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_add_days_defines.svh"

module gdad_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pop_valid,
  output      logic                              pop_ready,
  input  wire gdad_pkg::item_t                   pop_item,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [gdad_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output      logic                              m_tuser
);

  gdad_pkg::bk_state_t            state;
  gdad_pkg::bk_state_t            state_next;

  logic [gdad_pkg::YEAR_W-1:0]    year;
  logic [gdad_pkg::MONTH_W-1:0]   month;
  logic [gdad_pkg::REM_W-1:0]     rem;
  logic                           leap;

  logic [gdad_pkg::YEAR_W-1:0]    out_year;
  logic [gdad_pkg::MONTH_W-1:0]   out_month;
  logic [gdad_pkg::DAY_W-1:0]     out_day;
  logic                           out_bad;

  logic [gdad_pkg::DAY_W-1:0]     len;
  logic                           out_free;
  logic                           step;
  logic                           load;
  logic                           emit_bad;
  logic                           emit_walk;

  assign out_free = !m_tvalid || m_tready;
  assign len      = gdad_pkg::month_len(month, leap);
  assign m_tdata  = {1'b0, out_day, out_month, out_year};
  assign m_tuser  = out_bad;

  always_comb begin
    state_next = state;
    unique case (state)
      gdad_pkg::BK_IDLE: begin
        if (pop_valid && !pop_item.bad) begin
          state_next = gdad_pkg::BK_WALK;
        end
      end
      gdad_pkg::BK_WALK: begin
        if ((rem <= gdad_pkg::REM_W'(len)) && out_free) begin
          state_next = gdad_pkg::BK_IDLE;
        end
      end
      default: state_next = gdad_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load      = 1'b0;
    emit_bad  = 1'b0;
    step      = 1'b0;
    emit_walk = 1'b0;
    unique case (state)
      gdad_pkg::BK_IDLE: begin
        pop_ready = pop_item.bad ? out_free : 1'b1;
        load      = pop_valid && !pop_item.bad;
        emit_bad  = pop_valid && pop_item.bad && out_free;
      end
      gdad_pkg::BK_WALK: begin
        step      = (rem > gdad_pkg::REM_W'(len));
        emit_walk = !step && out_free;
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (load) begin
      year  <= pop_item.year;
      month <= gdad_pkg::JAN;
      rem   <= pop_item.rem;
      leap  <= pop_item.leap;
    end else if (step) begin
      rem <= rem - gdad_pkg::REM_W'(len);
      if (month == gdad_pkg::DEC) begin
        month <= gdad_pkg::JAN;
        year  <= year + gdad_pkg::YEAR_W'(1);
      end else begin
        month <= month + gdad_pkg::MONTH_W'(1);
      end
      // january never needs the flag, so refresh it there for february
      if (month == gdad_pkg::JAN) begin
        leap <= gdad_pkg::is_leap(year);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_bad || emit_walk) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_bad) begin
      out_year  <= pop_item.year;
      out_month <= pop_item.month;
      out_day   <= pop_item.day;
      out_bad   <= 1'b1;
    end else if (emit_walk) begin
      out_year  <= year;
      out_month <= month;
      out_day   <= rem[gdad_pkg::DAY_W-1:0];
      out_bad   <= 1'b0;
    end
  end

  `GDAD_ASSERT_NOW(a_walk_month, clk, rst, state == gdad_pkg::BK_WALK, (month >= gdad_pkg::JAN) && (month <= gdad_pkg::DEC), "month out of range during walk")
  `GDAD_ASSERT_NEXT(a_walk_shrinks, clk, rst, step, rem < $past(rem), "remaining days did not shrink")
  `GDAD_ASSERT_NOW(a_day_range, clk, rst, emit_walk, (rem >= gdad_pkg::REM_W'(1)) && (rem <= gdad_pkg::REM_W'(len)), "result day outside month")

endmodule

`default_nettype wire

// ===== sv/gregorian_date_add_days.sv =====
// top level of the gregorian date-add block: front, queue and back part
// depends on gdad_pkg, gdad_front, gdad_queue, gdad_back
//
// channel  dir  width  contents (lowest bit first)
// s_*      in   40     start_year[13:0], start_month[17:14], start_day[22:18],
//                      days_to_add[37:23], zero fill
// m_*      out  24+1   tdata: end_year[13:0], end_month[17:14], end_day[22:18],
//                      zero fill; tuser: bad_input
//
// a request is held in the front register, then waits in the queue
// the back part walks one month per cycle from january of the start year
// an invalid start date passes the back part without a month walk
// rst is synchronous; it empties the front register, queue and output slot
// the front keeps taking requests while the back walks, until the queue fills
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // start_year, start_month, start_day, days_to_add
  input  wire logic [gdad_pkg::IN_TDATA_W-1:0]   s_tdata,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // end_year, end_month, end_day
  output      logic [gdad_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // bad_input
  output      logic                              m_tuser
);

  // front to queue
  logic             push_valid;
  logic             push_ready;
  gdad_pkg::item_t  push_item;

  // queue to back
  logic             pop_valid;
  logic             pop_ready;
  gdad_pkg::item_t  pop_item;

  // validation and day-of-year sum
  gdad_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples the front from the long month walk
  gdad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // month walk and output register
  gdad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for gregorian_date_add_days: streams start dates and day counts,
// predicts each resulting date in the bench and checks every result in order
// depends on gdad_pkg and the gregorian_date_add_days rtl
module tb;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES    = 1200;   // a little over one worst-case month walk
  localparam int RANDOM_REQS    = 400;
  localparam int IDLE_PCT       = 18;
  localparam int CALM_FIRST     = 180;    // no idling on either side over this request span
  localparam int CALM_LAST      = 260;
  localparam int DRAIN_AT       = 300;    // random request that waits for an empty pipe

  localparam logic [gdad_pkg::MONTH_W-1:0] NO_MONTH  = 4'd0;
  localparam logic [gdad_pkg::MONTH_W-1:0] APR       = 4'd4;
  localparam logic [gdad_pkg::MONTH_W-1:0] TOP_MONTH = 4'd15;
  localparam logic [gdad_pkg::YEAR_W-1:0]  TOP_YEAR  = 14'd16383;
  localparam logic [gdad_pkg::ADD_W-1:0]   TOP_ADD   = 15'd32767;

  // month lengths of a common year, january first
  localparam logic [gdad_pkg::DAY_W-1:0] COMMON_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct {
    logic [gdad_pkg::YEAR_W-1:0]  year;
    logic [gdad_pkg::MONTH_W-1:0] month;
    logic [gdad_pkg::DAY_W-1:0]   day;
    logic [gdad_pkg::ADD_W-1:0]   add;
    bit                           hold;   // wait until every result is back before sending
  } date_req_t;

  typedef struct {
    logic [gdad_pkg::YEAR_W-1:0]  year;
    logic [gdad_pkg::MONTH_W-1:0] month;
    logic [gdad_pkg::DAY_W-1:0]   day;
    logic                         bad;
  } date_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  // start_year, start_month, start_day, days_to_add, zero fill
  logic [gdad_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // end_year, end_month, end_day, zero fill
  logic [gdad_pkg::OUT_TDATA_W-1:0] m_tdata;
  // bad_input
  logic                             m_tuser;

  date_req_t pending_reqs [$];
  date_res_t awaited_dates [$];

  int errors       = 0;
  int reqs_sent    = 0;
  int quiet_cycles = 0;
  bit req_taken    = 1'b0;
  bit calm         = 1'b0;

  gregorian_date_add_days u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic bit leap_year_of(input logic [gdad_pkg::YEAR_W-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // zero for a month code outside january..december
  function automatic logic [gdad_pkg::DAY_W-1:0] month_days(
      input logic [gdad_pkg::MONTH_W-1:0] m,
      input logic [gdad_pkg::YEAR_W-1:0]  y);
    if (m == gdad_pkg::FEB) begin
      return leap_year_of(y) ? gdad_pkg::FEB_LEAP_LEN : gdad_pkg::FEB_LEN;
    end
    if ((m < gdad_pkg::JAN) || (m > gdad_pkg::DEC)) begin
      return '0;
    end
    return COMMON_LEN[m - gdad_pkg::JAN];
  endfunction

  // date reached after r.add days; a bad start date comes back untouched
  function automatic date_res_t advance_date(input date_req_t r);
    date_res_t                    res;
    logic [gdad_pkg::DAY_W-1:0]   len;
    logic [gdad_pkg::MONTH_W-1:0] m;
    int unsigned                  days_left;
    res.year  = r.year;
    res.month = r.month;
    res.day   = r.day;
    res.bad   = 1'b1;
    len = month_days(r.month, r.year);
    if ((len == 0) || (r.day == 0) || (r.day > len)) begin
      return res;
    end
    // day of year of the start date plus the count
    days_left = 32'(r.day) + 32'(r.add);
    for (m = gdad_pkg::JAN; m < r.month; m++) begin
      days_left += 32'(month_days(m, r.year));
    end
    // walk whole months from january; strict compare keeps the day in 1..length
    res.bad   = 1'b0;
    res.month = gdad_pkg::JAN;
    while (days_left > 32'(month_days(res.month, res.year))) begin
      days_left -= 32'(month_days(res.month, res.year));
      if (res.month == gdad_pkg::DEC) begin
        res.month = gdad_pkg::JAN;
        res.year  = res.year + gdad_pkg::YEAR_W'(1);   // 14-bit year wraps past the top
      end else begin
        res.month = res.month + gdad_pkg::MONTH_W'(1);
      end
    end
    res.day = days_left[gdad_pkg::DAY_W-1:0];
    return res;
  endfunction

  task automatic queue_req(input logic [gdad_pkg::YEAR_W-1:0] y,
                           input logic [gdad_pkg::MONTH_W-1:0] m,
                           input logic [gdad_pkg::DAY_W-1:0] d,
                           input logic [gdad_pkg::ADD_W-1:0] a,
                           input bit hold);
    date_req_t r;
    r.year  = y;
    r.month = m;
    r.day   = d;
    r.add   = a;
    r.hold  = hold;
    pending_reqs.push_back(r);
  endtask

  // driver: presents requests at the falling edge, idles and stalls at random
  always @(negedge clk) begin
    date_req_t nxt;
    calm = (reqs_sent >= CALM_FIRST) && (reqs_sent < CALM_LAST);
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!s_tvalid || req_taken) begin
        req_taken = 1'b0;
        // a held request goes only once the pipe has drained
        if ((pending_reqs.size() != 0) && pending_reqs[0].hold &&
            (awaited_dates.size() == 0)) begin
          pending_reqs[0].hold = 1'b0;
        end
        if ((pending_reqs.size() == 0) || pending_reqs[0].hold ||
            (!calm && ($urandom_range(99) < IDLE_PCT))) begin
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          s_tdata  <= gdad_pkg::IN_TDATA_W'({nxt.add, nxt.day, nxt.month, nxt.year});
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin
    date_req_t seen;
    date_res_t want;
    date_res_t got;
    if (!rst) begin
      quiet_cycles++;
      if (s_tvalid && s_tready) begin
        seen.year  = s_tdata[gdad_pkg::YEAR_W-1:0];
        seen.month = s_tdata[gdad_pkg::YEAR_W +: gdad_pkg::MONTH_W];
        seen.day   = s_tdata[gdad_pkg::YEAR_W+gdad_pkg::MONTH_W +: gdad_pkg::DAY_W];
        seen.add   = s_tdata[gdad_pkg::YEAR_W+gdad_pkg::MONTH_W+gdad_pkg::DAY_W +:
                             gdad_pkg::ADD_W];
        seen.hold  = 1'b0;
        awaited_dates.push_back(advance_date(seen));
        req_taken = 1'b1;
        reqs_sent++;
        quiet_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got.year  = m_tdata[gdad_pkg::YEAR_W-1:0];
        got.month = m_tdata[gdad_pkg::YEAR_W +: gdad_pkg::MONTH_W];
        got.day   = m_tdata[gdad_pkg::YEAR_W+gdad_pkg::MONTH_W +: gdad_pkg::DAY_W];
        got.bad   = m_tuser;
        if (awaited_dates.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %0d-%0d-%0d bad %0b",
                   $time, got.year, got.month, got.day, got.bad);
        end else begin
          want = awaited_dates.pop_front();
          if (got.year !== want.year) begin
            errors++;
            $display("%0t: end_year expected %0d actual %0d", $time, want.year, got.year);
          end
          if (got.month !== want.month) begin
            errors++;
            $display("%0t: end_month expected %0d actual %0d", $time, want.month, got.month);
          end
          if (got.day !== want.day) begin
            errors++;
            $display("%0t: end_day expected %0d actual %0d", $time, want.day, got.day);
          end
          if (got.bad !== want.bad) begin
            errors++;
            $display("%0t: bad_input expected %0b actual %0b", $time, want.bad, got.bad);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("gregorian_date_add_days verification failed");
    $finish;
  end

  initial begin
    logic [gdad_pkg::YEAR_W-1:0]  y;
    logic [gdad_pkg::MONTH_W-1:0] m;
    logic [gdad_pkg::DAY_W-1:0]   d;
    logic [gdad_pkg::DAY_W-1:0]   len;
    logic [gdad_pkg::ADD_W-1:0]   a;
    int                           pick;

    // directed: field extremes, month ends, leap rules, bad dates, year zero, year wrap
    queue_req(14'd1, gdad_pkg::JAN, 5'd1, 15'd0, 1'b0);
    queue_req(14'd9999, gdad_pkg::DEC, 5'd31, TOP_ADD, 1'b0);
    queue_req(14'd2023, gdad_pkg::JAN, 5'd31, 15'd0, 1'b0);  // result stays on the month end
    queue_req(14'd2023, gdad_pkg::JAN, 5'd31, 15'd1, 1'b0);
    queue_req(14'd2023, gdad_pkg::FEB, 5'd28, 15'd1, 1'b0);  // common year
    queue_req(14'd2024, gdad_pkg::FEB, 5'd28, 15'd1, 1'b0);  // leap year
    queue_req(14'd1900, gdad_pkg::FEB, 5'd28, 15'd1, 1'b0);  // century, not leap
    queue_req(14'd2000, gdad_pkg::FEB, 5'd28, 15'd1, 1'b0);  // divisible by 400, leap
    queue_req(14'd2024, gdad_pkg::FEB, 5'd29, 15'd365, 1'b0);
    queue_req(14'd2023, gdad_pkg::DEC, 5'd31, 15'd1, 1'b1);  // year rollover, after a drain
    queue_req(14'd2023, NO_MONTH, 5'd15, 15'd10, 1'b0);      // month below range
    queue_req(14'd2023, gdad_pkg::DEC + 1'b1, 5'd15, 15'd10, 1'b0);
    queue_req(TOP_YEAR, TOP_MONTH, 5'd31, TOP_ADD, 1'b0);
    queue_req(14'd0, NO_MONTH, 5'd0, 15'd0, 1'b0);
    queue_req(14'd2023, gdad_pkg::JAN, 5'd0, 15'd5, 1'b0);   // day zero
    queue_req(14'd2023, APR, 5'd31, 15'd5, 1'b0);            // day past a 30-day month
    queue_req(14'd2023, gdad_pkg::FEB, 5'd29, 15'd5, 1'b0);  // leap day in a common year
    queue_req(14'd2024, gdad_pkg::FEB, 5'd30, 15'd5, 1'b0);
    queue_req(14'd0, gdad_pkg::FEB, 5'd29, 15'd0, 1'b0);     // year zero counts as leap
    queue_req(14'd0, gdad_pkg::JAN, 5'd1, TOP_ADD, 1'b0);
    queue_req(TOP_YEAR, gdad_pkg::DEC, 5'd31, 15'd1, 1'b0);  // year wraps to zero
    queue_req(TOP_YEAR, gdad_pkg::JAN, 5'd1, TOP_ADD, 1'b0);
    queue_req(14'd2000, gdad_pkg::DEC, 5'd31, TOP_ADD, 1'b0);

    // random: mostly valid dates with random content, some noise
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        y = gdad_pkg::YEAR_W'($urandom_range(9999, 1));
      end else if (pick < 80) begin
        y = gdad_pkg::YEAR_W'($urandom_range(TOP_YEAR, 0));
      end else if (pick < 90) begin
        y = gdad_pkg::YEAR_W'($urandom_range(TOP_YEAR, TOP_YEAR - 14'd100));
      end else begin
        y = gdad_pkg::YEAR_W'(400 * $urandom_range(40, 0));
      end
      m = ($urandom_range(99) < 90) ?
          gdad_pkg::MONTH_W'($urandom_range(gdad_pkg::DEC, gdad_pkg::JAN)) :
          gdad_pkg::MONTH_W'($urandom_range(TOP_MONTH, 0));
      len = month_days(m, y);
      if ((len != 0) && ($urandom_range(99) < 85)) begin
        d = ($urandom_range(99) < 20) ? len : gdad_pkg::DAY_W'($urandom_range(len, 1));
      end else begin
        d = gdad_pkg::DAY_W'($urandom_range(31, 0));
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        a = gdad_pkg::ADD_W'($urandom_range(400, 0));
      end else if (pick < 80) begin
        a = gdad_pkg::ADD_W'($urandom_range(4000, 0));
      end else begin
        a = gdad_pkg::ADD_W'($urandom_range(TOP_ADD, 0));
      end
      queue_req(y, m, d, a, i == DRAIN_AT);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((pending_reqs.size() != 0) || s_tvalid) begin
      @(negedge clk);
    end
    while (awaited_dates.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("gregorian_date_add_days verification clean");
    end else begin
      $display("gregorian_date_add_days verification failed");
    end
    $finish;
  end

endmodule
